// ===== src/assert_macros.svh =====
// Assertion helpers shared by the RTL. All checks run on clk and are off during rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== src/sapsq_pkg.sv =====
package sapsq_pkg;

  localparam int MAX_FRAMES = 256;
  localparam int FRAME_AW   = $clog2(MAX_FRAMES);
  localparam int COUNT_W    = $clog2(MAX_FRAMES + 1);

  // remainder divider: 33-bit dividend, one quotient bit per step
  localparam int DIV_STEPS  = 33;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  localparam logic [12:0] SPEED_MAX = 13'd4096;

  // operation codes
  localparam logic [2:0] OP_LOAD  = 3'd0;
  localparam logic [2:0] OP_PLAY  = 3'd1;
  localparam logic [2:0] OP_PAUSE = 3'd2;
  localparam logic [2:0] OP_STOP  = 3'd3;
  localparam logic [2:0] OP_SEEK  = 3'd4;
  localparam logic [2:0] OP_STEP  = 3'd5;
  localparam logic [2:0] OP_TICK  = 3'd6;

  // configuration register indexes
  localparam logic [1:0] REG_CLIP_DURATION  = 2'd0;
  localparam logic [1:0] REG_LOOPING        = 2'd1;
  localparam logic [1:0] REG_PLAYBACK_SPEED = 2'd2;
  localparam logic [1:0] REG_FRAME_COUNT    = 2'd3;

  typedef struct packed {
    logic [2:0]         operation;
    logic [7:0]         frame_slot;
    logic [31:0]        frame_length;
    logic [31:0]        time_amount;
    logic signed [15:0] frame_offset;
  } cmd_item_t;

  typedef struct packed {
    logic        accepted;
    logic [7:0]  current_frame;
    logic [31:0] time_in_frame;
    logic [31:0] clip_time;
    logic        is_playing;
    logic        is_finished;
  } rsp_item_t;

  // shared adder/subtractor request
  typedef struct packed {
    logic [32:0] a;
    logic [32:0] b;
    logic        sub;
  } alu_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_TADD,
    ST_TCMP,
    ST_DIV,
    ST_DIV_END,
    ST_SUM_START,
    ST_SUM,
    ST_LOC_START,
    ST_LOC,
    ST_DONE
  } state_t;

endpackage

// ===== src/sapsq_alu.sv =====
// 33-bit add / subtract; res[33] is the borrow on subtract.
module sapsq_alu (
  input  sapsq_pkg::alu_req_t req,
  output logic [33:0]         res
);

  always_comb begin
    if (req.sub) begin
      res = {1'b0, req.a} - {1'b0, req.b};
    end else begin
      res = {1'b0, req.a} + {1'b0, req.b};
    end
  end

endmodule

// ===== src/sprite_animation_playback_sequencer.sv =====
// Flip-book playback sequencer. One command transaction in, one response transaction out,
// one command at a time: cmd_stall stays high from acceptance until the response is in
// the output register (a waiting response does not block the next command). Path per
// command, from acceptance until the block can take a command again: load, pause, play
// while not finished, refused steps and ticks and undefined codes go from EXEC straight
// to DONE. Stop, seek and play after finished walk the table entry by entry, up to
// frame_count. A tick that moves adds its sum and compare plus the walk on a clamping
// clip, and the 33-step remainder divider plus the walk on a looping clip. A step walks
// the frames ahead of the target, after a remainder by the frame count on a looping clip.
// The worst case is a looping tick that walks all 256 entries.
// DONE holds while the receiver keeps the previous response.
// Time sums, compares, remainder steps and the table walk share one 33-bit
// adder/subtractor; the tick advance uses a 32x13 multiplier. The duration table is a
// single-port-write, registered-read memory with no reset and no clearing pass.
`include "assert_macros.svh"

module sprite_animation_playback_sequencer (
  input  logic                  clk,
  input  logic                  rst,
  // command channel
  input  logic                  cmd_valid,
  output logic                  cmd_stall,
  input  sapsq_pkg::cmd_item_t  cmd_item,
  // response channel
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output sapsq_pkg::rsp_item_t  rsp_item,
  // configuration writes
  input  logic                  cfg_write,
  input  logic [1:0]            cfg_index,
  input  logic [31:0]           cfg_data
);

  // ---------------------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------------------
  logic [31:0] clip_duration;
  logic        looping;
  logic [12:0] playback_speed;
  logic [8:0]  frame_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      clip_duration  <= 32'd65536;
      looping        <= 1'b1;
      playback_speed <= 13'd256;
      frame_count    <= 9'd1;
    end else if (cfg_write) begin
      case (cfg_index)
        sapsq_pkg::REG_CLIP_DURATION:  clip_duration <= cfg_data;
        sapsq_pkg::REG_LOOPING:        looping       <= cfg_data[0];
        sapsq_pkg::REG_PLAYBACK_SPEED: begin
          // speed saturates at 16.0x on write
          playback_speed <= (cfg_data[12:0] > sapsq_pkg::SPEED_MAX) ?
                            sapsq_pkg::SPEED_MAX : cfg_data[12:0];
        end
        sapsq_pkg::REG_FRAME_COUNT:    frame_count   <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // Effective clip length (zero acts as one) and frame count (clamped to 1..MAX_FRAMES).
  logic [31:0]                    dur;
  logic [sapsq_pkg::COUNT_W-1:0]  n_used;

  assign dur = (clip_duration == 32'd0) ? 32'd1 : clip_duration;

  always_comb begin
    if (frame_count == 9'd0) begin
      n_used = sapsq_pkg::COUNT_W'(1);
    end else if (32'(frame_count) > sapsq_pkg::MAX_FRAMES) begin
      n_used = sapsq_pkg::COUNT_W'(sapsq_pkg::MAX_FRAMES);
    end else begin
      n_used = sapsq_pkg::COUNT_W'(frame_count);
    end
  end

  // ---------------------------------------------------------------------------------------
  // Playback state and working registers
  // ---------------------------------------------------------------------------------------
  sapsq_pkg::state_t state, state_next;

  logic [31:0]                    elapsed;     // clip time
  logic [sapsq_pkg::FRAME_AW-1:0] pos;         // current frame
  logic [31:0]                    ftime;       // time inside current frame
  logic                           playing;
  logic                           finished;

  logic [2:0]                     op;
  logic [31:0]                    amount;
  logic signed [15:0]             offset;
  logic                           ok;

  logic [31:0]                    acc;         // walk remainder, running sum, div remainder
  logic [32:0]                    dq;          // dividend shifter, tick sum
  logic [31:0]                    dv;          // divisor
  logic [sapsq_pkg::DIV_CNT_W-1:0] cnt;
  logic [sapsq_pkg::FRAME_AW-1:0] idx;         // table walk index
  logic                           neg;         // step target was negative
  logic [44:0]                    prod;        // amount * speed

  logic cmd_take;
  logic rsp_load;

  assign cmd_stall = (state != sapsq_pkg::ST_IDLE);
  assign cmd_take  = cmd_valid && !cmd_stall;
  assign rsp_load  = (state == sapsq_pkg::ST_DONE) && !(rsp_valid && rsp_stall);

  // ---------------------------------------------------------------------------------------
  // Frame duration table: written at command acceptance, read one entry per cycle
  // ---------------------------------------------------------------------------------------
  logic [31:0]                    mem [sapsq_pkg::MAX_FRAMES];
  logic [31:0]                    rd_data;
  logic [sapsq_pkg::FRAME_AW-1:0] ra;
  logic                           mem_we;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cmd_item.frame_slot] <= cmd_item.frame_length;
    end
    rd_data <= mem[ra];
  end

  // ---------------------------------------------------------------------------------------
  // Shared adder / subtractor
  // ---------------------------------------------------------------------------------------
  sapsq_pkg::alu_req_t alu_req;
  logic [33:0]         alu_res;
  logic                borrow;

  sapsq_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  assign borrow = alu_res[33];

  // Derived values used by the datapath.
  logic [31:0]  adv;        // saturated tick advance
  logic [32:0]  trial;      // divider partial remainder
  logic [31:0]  sum_sat;    // saturated running sum
  logic signed [16:0] tgt;  // raw step target
  logic [16:0]  tgt_mag;
  logic [sapsq_pkg::COUNT_W-1:0] n_last;
  logic [8:0]   rem;
  logic [8:0]   wrapped;
  logic         slot_ok;

  assign adv     = (|prod[44:40]) ? 32'hFFFF_FFFF : prod[39:8];
  assign trial   = {acc, dq[32]};
  assign sum_sat = alu_res[32] ? 32'hFFFF_FFFF : alu_res[31:0];
  assign tgt     = $signed({9'd0, pos}) + $signed({offset[15], offset});
  assign tgt_mag = tgt[16] ? 17'(-tgt) : 17'(tgt);
  assign n_last  = n_used - sapsq_pkg::COUNT_W'(1);
  assign rem     = acc[8:0];
  assign wrapped = (neg && rem != 9'd0) ? (9'(n_used) - rem) : rem;
  assign slot_ok = ({1'b0, cmd_item.frame_slot} < 9'(sapsq_pkg::MAX_FRAMES));

  // ---------------------------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      sapsq_pkg::ST_IDLE: begin
        if (cmd_take) begin
          state_next = sapsq_pkg::ST_EXEC;
        end
      end
      sapsq_pkg::ST_EXEC: begin
        case (op)
          sapsq_pkg::OP_PLAY: begin
            state_next = finished ? sapsq_pkg::ST_LOC_START : sapsq_pkg::ST_DONE;
          end
          sapsq_pkg::OP_STOP,
          sapsq_pkg::OP_SEEK: state_next = sapsq_pkg::ST_LOC_START;
          sapsq_pkg::OP_STEP: begin
            if (offset == 16'sd0) begin
              state_next = sapsq_pkg::ST_DONE;
            end else if (looping) begin
              state_next = sapsq_pkg::ST_DIV;
            end else begin
              state_next = sapsq_pkg::ST_SUM_START;
            end
          end
          sapsq_pkg::OP_TICK: begin
            if (playing && amount != 32'd0 && playback_speed != 13'd0) begin
              state_next = sapsq_pkg::ST_TADD;
            end else begin
              state_next = sapsq_pkg::ST_DONE;
            end
          end
          default: state_next = sapsq_pkg::ST_DONE;
        endcase
      end
      sapsq_pkg::ST_TADD: begin
        state_next = looping ? sapsq_pkg::ST_DIV : sapsq_pkg::ST_TCMP;
      end
      sapsq_pkg::ST_TCMP: state_next = sapsq_pkg::ST_LOC_START;
      sapsq_pkg::ST_DIV: begin
        if (cnt == sapsq_pkg::DIV_CNT_W'(sapsq_pkg::DIV_STEPS - 1)) begin
          state_next = sapsq_pkg::ST_DIV_END;
        end
      end
      sapsq_pkg::ST_DIV_END: begin
        state_next = (op == sapsq_pkg::OP_STEP) ? sapsq_pkg::ST_SUM_START :
                                                  sapsq_pkg::ST_LOC_START;
      end
      sapsq_pkg::ST_SUM_START: begin
        state_next = (pos == '0) ? sapsq_pkg::ST_DONE : sapsq_pkg::ST_SUM;
      end
      sapsq_pkg::ST_SUM: begin
        if ({1'b0, idx} + 9'd1 == {1'b0, pos}) begin
          state_next = sapsq_pkg::ST_DONE;
        end
      end
      sapsq_pkg::ST_LOC_START: state_next = sapsq_pkg::ST_LOC;
      sapsq_pkg::ST_LOC: begin
        if (borrow || sapsq_pkg::COUNT_W'(idx) == n_last) begin
          state_next = sapsq_pkg::ST_DONE;
        end
      end
      sapsq_pkg::ST_DONE: begin
        if (rsp_load) begin
          state_next = sapsq_pkg::ST_IDLE;
        end
      end
      default: state_next = sapsq_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------------------
  // Sequencer: control outputs (ALU operands, table read address, table write)
  // ---------------------------------------------------------------------------------------
  always_comb begin
    alu_req = '0;
    ra      = '0;
    mem_we  = 1'b0;
    case (state)
      sapsq_pkg::ST_IDLE: begin
        mem_we = cmd_take && (cmd_item.operation == sapsq_pkg::OP_LOAD) && slot_ok;
      end
      sapsq_pkg::ST_EXEC: begin
        // seek: amount < dur ?
        alu_req = '{a: {1'b0, amount}, b: {1'b0, dur}, sub: 1'b1};
      end
      sapsq_pkg::ST_TADD: begin
        alu_req = '{a: {1'b0, elapsed}, b: {1'b0, adv}, sub: 1'b0};
      end
      sapsq_pkg::ST_TCMP: begin
        alu_req = '{a: dq, b: {1'b0, dur}, sub: 1'b1};
      end
      sapsq_pkg::ST_DIV: begin
        alu_req = '{a: trial, b: {1'b0, dv}, sub: 1'b1};
      end
      sapsq_pkg::ST_SUM: begin
        alu_req = '{a: {1'b0, acc}, b: {1'b0, rd_data}, sub: 1'b0};
        ra      = idx + sapsq_pkg::FRAME_AW'(1);
      end
      sapsq_pkg::ST_LOC: begin
        alu_req = '{a: {1'b0, acc}, b: {1'b0, rd_data}, sub: 1'b1};
        ra      = idx + sapsq_pkg::FRAME_AW'(1);
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------------------
  // Datapath
  // ---------------------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sapsq_pkg::ST_IDLE;
      elapsed   <= '0;
      pos       <= '0;
      ftime     <= '0;
      playing   <= 1'b0;
      finished  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;

      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end

      case (state)
        sapsq_pkg::ST_IDLE: begin
          if (cmd_take) begin
            op     <= cmd_item.operation;
            amount <= cmd_item.time_amount;
            offset <= cmd_item.frame_offset;
            ok     <= (cmd_item.operation == sapsq_pkg::OP_LOAD) && slot_ok;
          end
        end

        sapsq_pkg::ST_EXEC: begin
          case (op)
            sapsq_pkg::OP_PLAY: begin
              if (finished) begin
                elapsed  <= '0;
                finished <= 1'b0;
              end
              playing <= 1'b1;
              ok      <= 1'b1;
            end
            sapsq_pkg::OP_PAUSE: begin
              playing <= 1'b0;
              ok      <= 1'b1;
            end
            sapsq_pkg::OP_STOP: begin
              elapsed  <= '0;
              pos      <= '0;
              ftime    <= '0;
              playing  <= 1'b0;
              finished <= 1'b0;
              ok       <= 1'b1;
            end
            sapsq_pkg::OP_SEEK: begin
              // target clamps to the clip end; reaching it finishes a one-shot clip
              elapsed  <= borrow ? amount : dur;
              finished <= !looping && !borrow;
              if (!looping && !borrow) begin
                playing <= 1'b0;
              end
              ok <= 1'b1;
            end
            sapsq_pkg::OP_STEP: begin
              ok  <= (offset != 16'sd0);
              neg <= tgt[16];
              dq  <= {16'd0, tgt_mag};
              dv  <= 32'(n_used);
              acc <= '0;
              cnt <= '0;
              // a zero step leaves the cursor alone
              if (!looping && offset != 16'sd0) begin
                if (tgt[16]) begin
                  pos <= '0;
                end else if (tgt_mag > 17'(n_last)) begin
                  pos <= sapsq_pkg::FRAME_AW'(n_last);
                end else begin
                  pos <= tgt_mag[sapsq_pkg::FRAME_AW-1:0];
                end
              end
            end
            sapsq_pkg::OP_TICK: begin
              ok   <= playing && amount != 32'd0 && playback_speed != 13'd0;
              prod <= amount * playback_speed;
            end
            default: ;
          endcase
        end

        sapsq_pkg::ST_TADD: begin
          dq  <= alu_res[32:0];
          dv  <= dur;
          acc <= '0;
          cnt <= '0;
        end

        sapsq_pkg::ST_TCMP: begin
          // one-shot clip: clamp at the end and finish
          if (!borrow) begin
            elapsed  <= dur;
            finished <= 1'b1;
            playing  <= 1'b0;
          end else begin
            elapsed <= dq[31:0];
          end
        end

        sapsq_pkg::ST_DIV: begin
          // restoring remainder step
          acc <= borrow ? trial[31:0] : alu_res[31:0];
          dq  <= {dq[31:0], 1'b0};
          cnt <= cnt + sapsq_pkg::DIV_CNT_W'(1);
        end

        sapsq_pkg::ST_DIV_END: begin
          if (op == sapsq_pkg::OP_STEP) begin
            // floor-style wrap of a negative target
            pos <= wrapped[sapsq_pkg::FRAME_AW-1:0];
          end else begin
            elapsed  <= acc;
            finished <= 1'b0;
          end
        end

        sapsq_pkg::ST_SUM_START: begin
          acc <= '0;
          idx <= '0;
          if (pos == '0) begin
            elapsed  <= '0;
            ftime    <= '0;
            playing  <= 1'b0;
            finished <= 1'b0;
          end
        end

        sapsq_pkg::ST_SUM: begin
          acc <= sum_sat;
          idx <= idx + sapsq_pkg::FRAME_AW'(1);
          if ({1'b0, idx} + 9'd1 == {1'b0, pos}) begin
            elapsed  <= sum_sat;
            ftime    <= '0;
            playing  <= 1'b0;
            finished <= 1'b0;
          end
        end

        sapsq_pkg::ST_LOC_START: begin
          acc <= elapsed;
          idx <= '0;
        end

        sapsq_pkg::ST_LOC: begin
          // stop in the frame that still has time left, or in the last frame
          if (borrow || sapsq_pkg::COUNT_W'(idx) == n_last) begin
            pos   <= idx;
            ftime <= borrow ? acc : rd_data;
          end else begin
            acc <= alu_res[31:0];
            idx <= idx + sapsq_pkg::FRAME_AW'(1);
          end
        end

        default: ;
      endcase
    end
  end

  // Response register (payload, no reset).
  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp_item.accepted      <= ok;
      rsp_item.current_frame <= 8'(pos);
      rsp_item.time_in_frame <= ftime;
      rsp_item.clip_time     <= elapsed;
      rsp_item.is_playing    <= playing;
      rsp_item.is_finished   <= finished;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------------------
  `ASSERT_NEXT(a_take_to_exec, cmd_take, state == sapsq_pkg::ST_EXEC)
  `ASSERT_IMPLIES(a_rsp_from_done, $rose(rsp_valid), $past(state) == sapsq_pkg::ST_DONE)
  `ASSERT_IMPLIES(a_walk_in_range, state == sapsq_pkg::ST_LOC, sapsq_pkg::COUNT_W'(idx) < n_used)
  `ASSERT_IMPLIES(a_rem_below_div, state == sapsq_pkg::ST_DIV_END, acc < dv)

endmodule

// ===== bench/tb.sv =====
module tb;

  // Opcode 7 has no name in the package; the block must ignore it.
  localparam logic [2:0]  OP_UNDEFINED  = 3'd7;
  // Worst case per command: the longest block command plus the longest sender gap and
  // receiver stall, over roughly 1700 commands; taken a few times over.
  localparam int unsigned CYCLE_LIMIT   = 5_000_000;
  // Long receiver hold-off: starts once this many commands have gone in.
  localparam int unsigned SQUEEZE_AT    = 900;
  localparam int unsigned SQUEEZE_LEN   = 600;
  localparam int unsigned TAIL_CYCLES   = 400;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      cmd_valid = 1'b0;
  logic      cmd_stall;
  sapsq_pkg::cmd_item_t cmd_item  = '0;
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;
  sapsq_pkg::rsp_item_t rsp_item;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = sapsq_pkg::REG_CLIP_DURATION;
  logic [31:0] cfg_data  = '0;

  // Playback model: configuration copy
  logic [31:0] clip_len;
  logic        loop_on;
  logic [12:0] speed;
  logic [8:0]  count_reg;
  // Playback model: cursor and table
  logic [31:0] lengths_tbl [sapsq_pkg::MAX_FRAMES];
  logic [31:0] elapsed;
  logic [7:0]  cursor;
  logic [31:0] in_frame;
  logic        playing;
  logic        finished;

  sapsq_pkg::cmd_item_t pending_cmds [$];   // commands not yet offered
  sapsq_pkg::rsp_item_t expected_rsps [$];  // predicted responses, oldest first

  int unsigned cycles     = 0;
  int unsigned cmds_taken = 0;
  int unsigned fails      = 0;
  logic        cmd_acc    = 1'b0;  // command transaction at the last rising edge
  bit          quiet      = 1'b0;  // phase with no idling on either side
  int unsigned gap_left   = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left  = 0;
  bit          squeezed   = 1'b0;

  always #5 clk = ~clk;

  sprite_animation_playback_sequencer DUT (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_item  (cmd_item),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_item  (rsp_item),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // ---------------------------------------------------------------- playback model

  function automatic int unsigned frames_in_use();
    if (count_reg == 0) return 1;
    if (count_reg > sapsq_pkg::MAX_FRAMES) return sapsq_pkg::MAX_FRAMES;
    return count_reg;
  endfunction

  // zero clip length behaves as one tick of 16.16 time
  function automatic longint unsigned clip_used();
    return (clip_len == 0) ? 64'd1 : 64'(clip_len);
  endfunction

  // Walk the table from frame 0 until the elapsed time falls inside a frame.
  // The last frame in use absorbs any overshoot, capped at its own length.
  function automatic void find_cursor();
    int unsigned n;
    logic [31:0] left;
    n = frames_in_use();
    left = elapsed;
    for (int unsigned k = 0; k < n; k++) begin
      if (left < lengths_tbl[k] || k + 1 == n) begin
        cursor = 8'(k);
        in_frame = (left < lengths_tbl[k]) ? left : lengths_tbl[k];
        return;
      end
      left -= lengths_tbl[k];
    end
  endfunction

  function automatic sapsq_pkg::rsp_item_t playback_step(sapsq_pkg::cmd_item_t c);
    sapsq_pkg::rsp_item_t r;
    logic ok;
    longint unsigned dur, adv, total, t;
    longint tgt, n, off;
    ok = 1'b0;
    dur = clip_used();
    case (c.operation)
      sapsq_pkg::OP_LOAD: begin
        if (int'(c.frame_slot) < sapsq_pkg::MAX_FRAMES) begin
          lengths_tbl[c.frame_slot] = c.frame_length;
          ok = 1'b1;
        end
      end
      sapsq_pkg::OP_PLAY: begin
        // restart from zero once a clamped clip has run out
        if (finished) begin
          elapsed = '0;
          finished = 1'b0;
          find_cursor();
        end
        playing = 1'b1;
        ok = 1'b1;
      end
      sapsq_pkg::OP_PAUSE: begin
        playing = 1'b0;
        ok = 1'b1;
      end
      sapsq_pkg::OP_STOP: begin
        elapsed = '0;
        cursor = '0;
        in_frame = '0;
        playing = 1'b0;
        finished = 1'b0;
        find_cursor();
        ok = 1'b1;
      end
      sapsq_pkg::OP_SEEK: begin
        t = (64'(c.time_amount) < dur) ? 64'(c.time_amount) : dur;
        elapsed = t[31:0];
        finished = !loop_on && t >= dur;
        if (finished) playing = 1'b0;
        find_cursor();
        ok = 1'b1;
      end
      sapsq_pkg::OP_STEP: begin
        off = longint'($signed(c.frame_offset));
        // a zero step is refused and leaves everything alone
        if (off != 0) begin
          n = longint'(frames_in_use());
          tgt = longint'(cursor) + off;
          if (loop_on) begin
            tgt = tgt % n;
            if (tgt < 0) tgt += n;
          end else begin
            if (tgt < 0) tgt = 0;
            if (tgt > n - 1) tgt = n - 1;
          end
          total = 0;
          for (longint k = 0; k < tgt; k++) total += 64'(lengths_tbl[k]);
          elapsed = (total > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : total[31:0];
          cursor = 8'(tgt);
          in_frame = '0;
          finished = 1'b0;
          playing = 1'b0;
          ok = 1'b1;
        end
      end
      sapsq_pkg::OP_TICK: begin
        // only a playing clip with nonzero delta and nonzero speed moves
        if (playing && c.time_amount != 0 && speed != 0) begin
          adv = (64'(c.time_amount) * 64'(speed)) >> 8;
          if (adv > 64'hFFFF_FFFF) adv = 64'hFFFF_FFFF;
          total = 64'(elapsed) + adv;
          if (loop_on) begin
            elapsed = 32'(total % dur);
            finished = 1'b0;
          end else begin
            if (total >= dur) begin
              total = dur;
              finished = 1'b1;
              playing = 1'b0;
            end
            elapsed = total[31:0];
          end
          find_cursor();
          ok = 1'b1;
        end
      end
      default: ;
    endcase
    r.accepted      = ok;
    r.current_frame = cursor;
    r.time_in_frame = in_frame;
    r.clip_time     = elapsed;
    r.is_playing    = playing;
    r.is_finished   = finished;
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus helpers

  function automatic sapsq_pkg::cmd_item_t mk(logic [2:0] op, logic [7:0] slot,
                                              logic [31:0] len, logic [31:0] amt,
                                              logic [15:0] off);
    sapsq_pkg::cmd_item_t c;
    c.operation    = op;
    c.frame_slot   = slot;
    c.frame_length = len;
    c.time_amount  = amt;
    c.frame_offset = off;
    return c;
  endfunction

  // mostly short, now and then a long one
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(40, 200);
  endfunction

  function automatic logic [31:0] table_sum(int unsigned n);
    longint unsigned s;
    s = 0;
    for (int unsigned k = 0; k < n; k++) s += 64'(lengths_tbl[k]);
    return (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  // Half play/tick traffic so the cursor keeps moving; unused fields carry junk.
  function automatic sapsq_pkg::cmd_item_t random_cmd();
    sapsq_pkg::cmd_item_t c;
    int unsigned pick, mode, mag;
    c = mk(sapsq_pkg::OP_TICK, 8'($urandom()), $urandom(), $urandom(), 16'($urandom()));
    pick = $urandom_range(0, 99);
    mode = $urandom_range(0, 19);
    if (pick < 36) begin
      c.operation = sapsq_pkg::OP_TICK;
      if (mode == 0) c.time_amount = '0;
      else if (mode == 1) c.time_amount = 32'hFFFF_FFFF;
      else if (mode > 3) c.time_amount = $urandom_range(1, 32'h6000);
    end else if (pick < 50) begin
      c.operation = sapsq_pkg::OP_PLAY;
    end else if (pick < 56) begin
      c.operation = sapsq_pkg::OP_PAUSE;
    end else if (pick < 60) begin
      c.operation = sapsq_pkg::OP_STOP;
    end else if (pick < 70) begin
      c.operation = sapsq_pkg::OP_SEEK;
      if (mode == 0) c.time_amount = '0;
      else if (mode == 1) c.time_amount = 32'hFFFF_FFFF;
      else if (mode == 2) c.time_amount = clip_len;
      else if (mode > 3) c.time_amount = $urandom_range(0, clip_len);
    end else if (pick < 82) begin
      c.operation = sapsq_pkg::OP_STEP;
      if (mode == 0) c.frame_offset = '0;
      else if (mode == 1) c.frame_offset = 16'h8000;
      else if (mode == 2) c.frame_offset = 16'h7FFF;
      else if (mode > 3) begin
        mag = (mode < 12) ? $urandom_range(1, 4) : $urandom_range(1, frames_in_use() + 2);
        c.frame_offset = $urandom_range(0, 1) ? 16'(mag) : 16'(-int'(mag));
      end
    end else if (pick < 98) begin
      c.operation = sapsq_pkg::OP_LOAD;
      if (mode < 16) c.frame_slot = 8'($urandom_range(0, frames_in_use() - 1));
      if (mode == 0) c.frame_length = '0;
      else if (mode == 1) c.frame_length = 32'hFFFF_FFFF;
      else if (mode > 2) c.frame_length = $urandom_range(32'h800, 32'h2_0000);
    end else begin
      c.operation = OP_UNDEFINED;
    end
    return c;
  endfunction

  // one register write per falling edge; the model follows at once
  task automatic set_reg(logic [1:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      sapsq_pkg::REG_CLIP_DURATION:  clip_len = data;
      sapsq_pkg::REG_LOOPING:        loop_on = data[0];
      sapsq_pkg::REG_PLAYBACK_SPEED: begin
        speed = (data[12:0] > sapsq_pkg::SPEED_MAX) ? sapsq_pkg::SPEED_MAX : data[12:0];
      end
      sapsq_pkg::REG_FRAME_COUNT:    count_reg = data[8:0];
      default: ;
    endcase
  endtask

  // bits above each register's width carry junk and must be dropped
  task automatic configure(logic [31:0] clip, logic lp, logic [12:0] spd, logic [8:0] cnt);
    set_reg(sapsq_pkg::REG_CLIP_DURATION, clip);
    set_reg(sapsq_pkg::REG_LOOPING, ($urandom() & 32'hFFFF_FFFE) | 32'(lp));
    set_reg(sapsq_pkg::REG_PLAYBACK_SPEED, ($urandom() & 32'hFFFF_E000) | 32'(spd));
    set_reg(sapsq_pkg::REG_FRAME_COUNT, ($urandom() & 32'hFFFF_FE00) | 32'(cnt));
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // every command answers, so the block is idle once the last response is out
  task automatic settle();
    while (pending_cmds.size() != 0 || expected_rsps.size() != 0 || cmd_valid)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic run_random(logic [31:0] clip, logic lp, logic [12:0] spd, logic [8:0] cnt,
                            int unsigned n, bit calm);
    settle();
    configure(clip, lp, spd, cnt);
    quiet = calm;
    repeat (n) pending_cmds.push_back(random_cmd());
  endtask

  // ---------------------------------------------------------------- command driver

  always @(negedge clk) begin : cmd_driver
    logic nv;
    sapsq_pkg::cmd_item_t ni;
    nv = cmd_valid;
    ni = cmd_item;
    if (rst) begin
      nv = 1'b0;
    end else begin
      if (cmd_valid && cmd_acc) begin
        nv = 1'b0;
        gap_left = quiet ? 0 : idle_len();
      end
      if (!nv) begin
        if (gap_left != 0) gap_left--;
        else if (pending_cmds.size() != 0) begin
          ni = pending_cmds.pop_front();
          nv = 1'b1;
        end
      end
    end
    // single update per edge so a back-to-back valid never dips
    cmd_valid <= nv;
    cmd_item  <= ni;
  end

  // ---------------------------------------------------------------- response throttle

  always @(negedge clk) begin : rsp_throttle
    if (rst) begin
      rsp_stall <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      rsp_stall <= 1'b1;
    end else if (!squeezed && cmds_taken >= SQUEEZE_AT) begin
      // long hold-off: the block backs up and must stall its command side
      squeezed = 1'b1;
      hold_left = SQUEEZE_LEN - 1;
      stall_left = 0;
      rsp_stall <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left--;
    end else begin
      stall_left = quiet ? 0 : idle_len();
      if (stall_left != 0) begin
        rsp_stall <= 1'b1;
        stall_left--;
      end else begin
        rsp_stall <= 1'b0;
        stall_left = $urandom_range(0, 7);
      end
    end
  end

  // ---------------------------------------------------------------- monitor / checker

  always @(posedge clk) begin : observe
    sapsq_pkg::rsp_item_t want;
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end else begin
      cmd_acc <= !rst && cmd_valid && !cmd_stall;
      // check before predicting: a response never belongs to this edge's command
      if (!rst && rsp_valid && !rsp_stall) begin
        if (expected_rsps.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("cycle %0d: response transaction with nothing outstanding", cycles);
        end else begin
          want = expected_rsps.pop_front();
          if (rsp_item.accepted !== want.accepted ||
              rsp_item.current_frame !== want.current_frame ||
              rsp_item.time_in_frame !== want.time_in_frame ||
              rsp_item.clip_time !== want.clip_time ||
              rsp_item.is_playing !== want.is_playing ||
              rsp_item.is_finished !== want.is_finished) begin
            fails++;
            if (fails <= 10) begin
              $display("cycle %0d mismatch: want acc=%0b frm=%0d tif=%h clip=%h play=%0b fin=%0b",
                       cycles, want.accepted, want.current_frame, want.time_in_frame,
                       want.clip_time, want.is_playing, want.is_finished);
              $display("                   got acc=%0b frm=%0d tif=%h clip=%h play=%0b fin=%0b",
                       rsp_item.accepted, rsp_item.current_frame, rsp_item.time_in_frame,
                       rsp_item.clip_time, rsp_item.is_playing, rsp_item.is_finished);
            end
          end
        end
      end
      if (!rst && cmd_valid && !cmd_stall) begin
        expected_rsps.push_back(playback_step(cmd_item));
        cmds_taken++;
      end
    end
  end

  // ---------------------------------------------------------------- test sequence

  initial begin
    int unsigned cnt;
    logic [31:0] clip;
    clip_len  = 32'h0001_0000;
    loop_on   = 1'b1;
    speed     = 13'd256;
    count_reg = 9'd1;
    elapsed   = '0;
    cursor    = '0;
    in_frame  = '0;
    playing   = 1'b0;
    finished  = 1'b0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // The duration table has no reset: load every entry before anything walks it.
    for (int s = 0; s < sapsq_pkg::MAX_FRAMES; s++)
      pending_cmds.push_back(mk(sapsq_pkg::OP_LOAD, 8'(s),
                                $urandom_range(32'h1000, 32'h1_8000),
                                $urandom(), 16'($urandom())));
    settle();

    // Directed: four frames, 1 s, 0 s, 2 s, max; clip of 4 s, clamping.
    configure(32'h0004_0000, 1'b0, 13'd256, 9'd4);
    pending_cmds.push_back(mk(sapsq_pkg::OP_LOAD, 8'd0, 32'h0001_0000, '0, '0));
    pending_cmds.push_back(mk(sapsq_pkg::OP_LOAD, 8'd1, 32'h0000_0000, '0, '0));
    pending_cmds.push_back(mk(sapsq_pkg::OP_LOAD, 8'd2, 32'h0002_0000, '0, '0));
    pending_cmds.push_back(mk(sapsq_pkg::OP_LOAD, 8'd3, 32'hFFFF_FFFF, '0, '0));
    pending_cmds.push_back(mk(sapsq_pkg::OP_LOAD, 8'hFF, 32'hFFFF_FFFF, '1, '1));
    // not playing
    pending_cmds.push_back(mk(sapsq_pkg::OP_TICK, '0, '0, 32'h0000_8000, '0));
    pending_cmds.push_back(mk(sapsq_pkg::OP_PLAY, '0, '0, '0, '0));
    // zero delta
    pending_cmds.push_back(mk(sapsq_pkg::OP_TICK, '0, '0, 32'h0000_0000, '0));
    // skips empty frame
    pending_cmds.push_back(mk(sapsq_pkg::OP_TICK, '0, '0, 32'h0001_8000, '0));
    // clamps, finishes
    pending_cmds.push_back(mk(sapsq_pkg::OP_TICK, '0, '0, 32'hFFFF_FFFF, '0));
    // finished, ignored
    pending_cmds.push_back(mk(sapsq_pkg::OP_TICK, '0, '0, 32'h0000_0100, '0));
    // restart from zero
    pending_cmds.push_back(mk(sapsq_pkg::OP_PLAY, '0, '0, '0, '0));
    pending_cmds.push_back(mk(sapsq_pkg::OP_PAUSE, '0, '0, '0, '0));
    pending_cmds.push_back(mk(sapsq_pkg::OP_SEEK, '0, '0, 32'h0003_0000, '0));
    // past end
    pending_cmds.push_back(mk(sapsq_pkg::OP_SEEK, '0, '0, 32'hFFFF_FFFF, '0));
    // refused
    pending_cmds.push_back(mk(sapsq_pkg::OP_STEP, '0, '0, '0, 16'h0000));
    pending_cmds.push_back(mk(sapsq_pkg::OP_STEP, '0, '0, '0, 16'h0001));
    // clamps low
    pending_cmds.push_back(mk(sapsq_pkg::OP_STEP, '0, '0, '0, 16'h8000));
    // clamps high
    pending_cmds.push_back(mk(sapsq_pkg::OP_STEP, '0, '0, '0, 16'h7FFF));
    pending_cmds.push_back(mk(sapsq_pkg::OP_STOP, '0, '0, '0, '0));
    pending_cmds.push_back(mk(OP_UNDEFINED, '1, '1, '1, '1));

    // Register extremes: zero length and zero count, oversized speed and count, zero speed.
    run_random(32'h0000_0000, 1'b1, 13'd8191, 9'd0, 120, 1'b0);
    run_random(32'hFFFF_FFFF, 1'b0, 13'd0, 9'd511, 60, 1'b1);
    run_random(table_sum(8), 1'b1, 13'd256, 9'd8, 200, 1'b0);
    run_random(table_sum(16) - 32'h100, 1'b0, 13'($urandom_range(1, 4096)), 9'd16, 200,
               1'b0);
    run_random(32'hFFFF_FFFF, 1'b1, 13'd4096, 9'd256, 150, 1'b1);
    run_random(32'h0000_0001, 1'b0, 13'd1, 9'd1, 80, 1'b0);
    for (int i = 0; i < 5; i++) begin
      cnt = (i == 2) ? $urandom_range(100, 256) : $urandom_range(1, 32);
      clip = (i % 2 == 1) ? table_sum(cnt) : $urandom_range(1, table_sum(cnt));
      run_random(clip, 1'($urandom_range(0, 1)), 13'($urandom_range(1, 1024)), 9'(cnt),
                 120, i == 3);
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fails == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

endmodule
